/* rtl/kti_pkg.sv */
// Shared types and constants for the keyframe transform interpolator.
package kti_pkg;

    localparam int CLIPS_DEF  = 8;
    localparam int KEYS_DEF   = 16;
    localparam int CH_N       = 5;
    localparam int CH_W       = 3;
    localparam int VAL_W      = 32;
    localparam int WORD_W     = VAL_W * (CH_N + 1);
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = 5;
    localparam int SPEED_W    = 16;
    localparam int SPEED_FRAC = 8;
    localparam int ELAP_W     = VAL_W + SPEED_W - SPEED_FRAC;
    localparam int LEN_W      = 5;
    localparam int KEY_W      = 4;
    localparam int CLIP_IN_W  = 3;
    localparam int OP_W       = 3;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_PLAY   = 3'd2,
        OP_REPLAY = 3'd3,
        OP_STOP   = 3'd4,
        OP_TICK   = 3'd5
    } kti_op_t;

    typedef struct packed {
        logic            latch;
        logic            exec;
        logic            rd_k2;
        logic            cap_k1;
        logic            cap_k2;
        logic            calc;
        logic            mul;
        logic            div_load;
        logic            div_step;
        logic            ch_store;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } kti_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic out_free;
    } kti_stat_t;

endpackage

/* rtl/kti_ctrl.sv */
// Sequencer for the keyframe interpolator: decode, key fetch, per-channel divide.
module kti_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  kti_pkg::kti_stat_t stat,
    output kti_pkg::kti_cmd_t  cmd
);
    import kti_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD2,
        ST_CAP2,
        ST_CALC,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [STEP_W-1:0]   step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_DECODE;
                end
                ST_DECODE:
                begin
                    state_reg <= stat.tick_go ? ST_RD2 : ST_EMIT;
                end
                ST_RD2:   state_reg <= ST_CAP2;
                ST_CAP2:  state_reg <= ST_CALC;
                ST_CALC:
                begin
                    ch_reg    <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DLOAD;
                end
                ST_DLOAD: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    if (ch_reg == CH_W'(CH_N - 1))
                        state_reg <= ST_EMIT;
                    else
                    begin
                        ch_reg    <= ch_reg + CH_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    if (stat.out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.latch    = (state_reg == ST_IDLE) && in_valid;
        cmd.exec     = (state_reg == ST_DECODE);
        cmd.rd_k2    = (state_reg == ST_RD2);
        cmd.cap_k1   = (state_reg == ST_RD2);
        cmd.cap_k2   = (state_reg == ST_CAP2);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_load = (state_reg == ST_DLOAD);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.ch_store = (state_reg == ST_STORE);
        cmd.out_load = (state_reg == ST_EMIT) && stat.out_free;
        cmd.ch       = ch_reg;
    end

endmodule

/* rtl/kti_datapath.sv */
// Keyframe store, playback state, elapsed-time multiplier and serial divider.
module kti_datapath #(
    parameter int CLIPS = kti_pkg::CLIPS_DEF,
    parameter int KEYS  = kti_pkg::KEYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kti_pkg::kti_cmd_t                 cmd,
    output kti_pkg::kti_stat_t                stat,
    input  logic                              cfg_we,
    input  logic [kti_pkg::SPEED_W-1:0]       cfg_speed,
    input  logic [kti_pkg::OP_W-1:0]          op,
    input  logic [kti_pkg::CLIP_IN_W-1:0]     clip,
    input  logic [kti_pkg::KEY_W-1:0]         slot,
    input  logic                              key_last,
    input  logic [31:0]                       key_time,
    input  logic signed [31:0]                key_pos_x,
    input  logic signed [31:0]                key_pos_y,
    input  logic signed [31:0]                key_rotation,
    input  logic signed [31:0]                key_scale_x,
    input  logic signed [31:0]                key_scale_y,
    input  logic [31:0]                       now,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              transform_valid,
    output logic signed [31:0]                out_pos_x,
    output logic signed [31:0]                out_pos_y,
    output logic signed [31:0]                out_rotation,
    output logic signed [31:0]                out_scale_x,
    output logic signed [31:0]                out_scale_y,
    output logic                              key_event,
    output logic [kti_pkg::KEY_W-1:0]         event_index,
    output logic                              is_playing
);
    import kti_pkg::*;

    localparam int DEPTH = CLIPS * KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (CLIPS > 1) ? $clog2(CLIPS) : 1;

    // latched item
    logic [OP_W-1:0]      op_reg;
    logic [CLIP_IN_W-1:0] clip_reg;
    logic [KEY_W-1:0]     slot_reg;
    logic                 last_reg;
    logic [VAL_W-1:0]     ktime_reg;
    logic [VAL_W-1:0]     kval_reg [CH_N];
    logic [VAL_W-1:0]     now_reg;

    // playback state
    logic                 playing_reg;
    logic [CW-1:0]        cur_clip_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     start_reg;
    logic [LEN_W-1:0]     play_len_reg;
    logic [LEN_W-1:0]     len_reg [CLIPS];
    logic [SPEED_W-1:0]   speed_reg;

    // keyframe store: time in the low word, channels above it
    logic [WORD_W-1:0]    mem [DEPTH];
    logic [WORD_W-1:0]    rd_data_reg;

    // tick arithmetic
    logic [ELAP_W-1:0]    elapsed_reg;
    logic [WORD_W-1:0]    k1_reg;
    logic [WORD_W-1:0]    k2_reg;
    logic [VAL_W-1:0]     n_reg;
    logic [VAL_W-1:0]     d_reg;
    logic                 flat_reg;
    logic                 neg_reg;
    logic [2*VAL_W-1:0]   prod_reg;
    logic [VAL_W-1:0]     rem_reg;
    logic [VAL_W-1:0]     sh_reg;
    logic [VAL_W-1:0]     res_ch_reg [CH_N];
    logic                 res_valid_reg;
    logic                 res_ev_reg;
    logic [KEY_W-1:0]     res_evidx_reg;

    logic                 out_valid_reg;
    logic                 out_tv_reg;
    logic [VAL_W-1:0]     out_ch_reg [CH_N];
    logic                 out_ev_reg;
    logic [KEY_W-1:0]     out_evidx_reg;
    logic                 out_play_reg;

    logic                 clip_ok;
    logic                 slot_ok;
    logic [CW-1:0]        clip_idx;
    logic [LEN_W-1:0]     len_sel;
    logic [LEN_W-1:0]     new_len;
    logic                 play_ok;
    logic                 tick_run;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_base;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic [WORD_W-1:0]    wr_word;
    logic [47:0]          emul;
    logic [VAL_W-1:0]     t1;
    logic [VAL_W-1:0]     t2;
    logic [VAL_W-1:0]     tm0;
    logic [VAL_W-1:0]     tm;
    logic                 reached;
    logic [VAL_W-1:0]     v1;
    logic [VAL_W-1:0]     v2;
    logic [VAL_W:0]       diff;
    logic [VAL_W:0]       ndiff;
    logic [VAL_W-1:0]     mag;
    logic [2*VAL_W-1:0]   mprod;
    logic [VAL_W:0]       r2;
    logic                 ge;
    logic [VAL_W:0]       r2_sub;
    logic [VAL_W-1:0]     lerp;

    assign clip_ok  = 32'(clip_reg) < 32'(CLIPS);
    assign slot_ok  = 32'(slot_reg) < 32'(KEYS);
    assign clip_idx = CW'(clip_reg);
    assign len_sel  = len_reg[clip_idx];
    assign new_len  = LEN_W'(slot_reg) + LEN_W'(1);
    assign play_ok  = clip_ok && (len_sel != '0);
    assign tick_run = playing_reg && ((LEN_W'(key_reg) + LEN_W'(1)) < play_len_reg);

    assign stat.tick_go  = (op_reg == OP_TICK) && tick_run;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign wr_addr = AW'(clip_idx) * AW'(KEYS) + AW'(slot_reg);
    assign rd_base = AW'(cur_clip_reg) * AW'(KEYS) + AW'(key_reg);
    assign rd_addr = cmd.rd_k2 ? rd_base + AW'(1) : rd_base;
    assign mem_we  = cmd.exec && (op_reg == OP_LOAD) && clip_ok && slot_ok;
    assign mem_re  = cmd.exec || cmd.rd_k2;
    assign wr_word = {kval_reg[4], kval_reg[3], kval_reg[2], kval_reg[1], kval_reg[0],
                      ktime_reg};

    assign emul = {16'b0, now_reg - start_reg} * {32'b0, speed_reg};

    // clamp elapsed into [t1, t2]
    assign t1      = k1_reg[VAL_W-1:0];
    assign t2      = k2_reg[VAL_W-1:0];
    assign reached = elapsed_reg >= ELAP_W'(t2);
    assign tm0     = reached ? t2 : elapsed_reg[VAL_W-1:0];
    assign tm      = (tm0 < t1) ? t1 : tm0;

    assign v1    = k1_reg[VAL_W*(32'(cmd.ch) + 1) +: VAL_W];
    assign v2    = k2_reg[VAL_W*(32'(cmd.ch) + 1) +: VAL_W];
    assign diff  = {v2[VAL_W-1], v2} - {v1[VAL_W-1], v1};
    assign ndiff = -diff;
    assign mag   = diff[VAL_W] ? ndiff[VAL_W-1:0] : diff[VAL_W-1:0];
    assign mprod = mag * n_reg;

    // restoring divide step, one quotient bit per cycle
    assign r2     = {rem_reg, sh_reg[VAL_W-1]};
    assign r2_sub = r2 - {1'b0, d_reg};
    assign ge     = r2 >= {1'b0, d_reg};
    assign lerp   = neg_reg ? v1 - sh_reg : v1 + sh_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_word;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg   <= 1'b0;
            cur_clip_reg  <= '0;
            key_reg       <= '0;
            start_reg     <= '0;
            play_len_reg  <= '0;
            speed_reg     <= SPEED_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CLIPS; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                speed_reg <= cfg_speed;
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (clip_ok && slot_ok && last_reg)
                        begin
                            len_reg[clip_idx] <= new_len;
                            if (clip_idx == cur_clip_reg)
                                play_len_reg <= new_len;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (clip_ok)
                        begin
                            if (playing_reg && (cur_clip_reg == clip_idx))
                            begin
                                playing_reg <= 1'b0;
                                start_reg   <= now_reg;
                                key_reg     <= '0;
                            end
                            len_reg[clip_idx] <= '0;
                        end
                    end
                    OP_PLAY:
                    begin
                        if (play_ok)
                        begin
                            playing_reg  <= 1'b1;
                            cur_clip_reg <= clip_idx;
                            play_len_reg <= len_sel;
                            start_reg    <= now_reg;
                            key_reg      <= '0;
                        end
                    end
                    OP_REPLAY:
                    begin
                        start_reg <= now_reg;
                        key_reg   <= '0;
                    end
                    OP_STOP:
                    begin
                        playing_reg <= 1'b0;
                        start_reg   <= now_reg;
                        key_reg     <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.calc && reached)
                key_reg <= key_reg + KEY_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= op;
            clip_reg    <= clip;
            slot_reg    <= slot;
            last_reg    <= key_last;
            ktime_reg   <= key_time;
            kval_reg[0] <= key_pos_x;
            kval_reg[1] <= key_pos_y;
            kval_reg[2] <= key_rotation;
            kval_reg[3] <= key_scale_x;
            kval_reg[4] <= key_scale_y;
            now_reg     <= now;
        end
        if (cmd.exec)
        begin
            elapsed_reg   <= emul[47:SPEED_FRAC];
            res_valid_reg <= stat.tick_go;
            res_ev_reg    <= (op_reg == OP_PLAY) && play_ok;
            res_evidx_reg <= '0;
            for (int c = 0; c < CH_N; c++)
                res_ch_reg[c] <= '0;
        end
        if (cmd.cap_k1)
            k1_reg <= rd_data_reg;
        if (cmd.cap_k2)
            k2_reg <= rd_data_reg;
        if (cmd.calc)
        begin
            n_reg    <= tm - t1;
            d_reg    <= t2 - t1;
            flat_reg <= !(t2 > t1);
            if (reached)
            begin
                res_ev_reg    <= 1'b1;
                res_evidx_reg <= key_reg + KEY_W'(1);
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= mprod;
            neg_reg  <= diff[VAL_W];
        end
        if (cmd.div_load)
        begin
            rem_reg <= prod_reg[2*VAL_W-1:VAL_W];
            sh_reg  <= prod_reg[VAL_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? r2_sub[VAL_W-1:0] : r2[VAL_W-1:0];
            sh_reg  <= {sh_reg[VAL_W-2:0], ge};
        end
        if (cmd.ch_store)
            res_ch_reg[cmd.ch] <= flat_reg ? v2 : lerp;
        if (cmd.out_load)
        begin
            out_tv_reg    <= res_valid_reg;
            out_ev_reg    <= res_ev_reg;
            out_evidx_reg <= res_evidx_reg;
            out_play_reg  <= playing_reg;
            for (int c = 0; c < CH_N; c++)
                out_ch_reg[c] <= res_ch_reg[c];
        end
    end

    assign out_valid       = out_valid_reg;
    assign transform_valid = out_tv_reg;
    assign out_pos_x       = out_ch_reg[0];
    assign out_pos_y       = out_ch_reg[1];
    assign out_rotation    = out_ch_reg[2];
    assign out_scale_x     = out_ch_reg[3];
    assign out_scale_y     = out_ch_reg[4];
    assign key_event       = out_ev_reg;
    assign event_index     = out_evidx_reg;
    assign is_playing      = out_play_reg;

endmodule

/* rtl/keyframe_transform_interpolator_core.sv */
// Top level of the keyframe transform interpolator: sequencer plus datapath.
//
// Usage: one command per input transfer (load keyframe, clear, play, replay,
// stop, tick); every command returns exactly one result transfer.
// Input channel: in_valid / in_stall, the block holds in_stall while an item
// is in work. Output channel: out_valid / out_stall, one output register, so
// a waiting result does not keep the block from taking the next item.
// Configuration: cfg_valid / cfg_ready carry the speed register (Q8.8); it
// is taken in any cycle and must only change while the block is idle.
// A non-tick command goes from decode straight to emit. A tick that
// interpolates first makes two reads of the keyframe store, then per channel
// one multiply, a 32-step serial divide and a store, for five channels through
// one shared divider.
// The next item is taken only once the last has been emitted, which waits while
// out_stall holds the output register full.
// Reset (rst_n low, asynchronous) stops playback, empties every clip and sets
// speed to 256; keyframe contents are undefined until loaded.
module keyframe_transform_interpolator_core #(
    parameter int CLIPS = kti_pkg::CLIPS_DEF,
    parameter int KEYS  = kti_pkg::KEYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kti_pkg::OP_W-1:0]      op,
    input  logic [kti_pkg::CLIP_IN_W-1:0] clip,
    input  logic [kti_pkg::KEY_W-1:0]     slot,
    input  logic                          key_last,
    input  logic [31:0]                   key_time,
    input  logic signed [31:0]            key_pos_x,
    input  logic signed [31:0]            key_pos_y,
    input  logic signed [31:0]            key_rotation,
    input  logic signed [31:0]            key_scale_x,
    input  logic signed [31:0]            key_scale_y,
    input  logic [31:0]                   now,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          transform_valid,
    output logic signed [31:0]            out_pos_x,
    output logic signed [31:0]            out_pos_y,
    output logic signed [31:0]            out_rotation,
    output logic signed [31:0]            out_scale_x,
    output logic signed [31:0]            out_scale_y,
    output logic                          key_event,
    output logic [kti_pkg::KEY_W-1:0]     event_index,
    output logic                          is_playing,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kti_pkg::SPEED_W-1:0]   speed
);
    import kti_pkg::*;

    kti_cmd_t  cmd;
    kti_stat_t stat;

    assign cfg_ready = 1'b1;

    kti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    kti_datapath #(
        .CLIPS (CLIPS),
        .KEYS  (KEYS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_speed       (speed),
        .op              (op),
        .clip            (clip),
        .slot            (slot),
        .key_last        (key_last),
        .key_time        (key_time),
        .key_pos_x       (key_pos_x),
        .key_pos_y       (key_pos_y),
        .key_rotation    (key_rotation),
        .key_scale_x     (key_scale_x),
        .key_scale_y     (key_scale_y),
        .now             (now),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .transform_valid (transform_valid),
        .out_pos_x       (out_pos_x),
        .out_pos_y       (out_pos_y),
        .out_rotation    (out_rotation),
        .out_scale_x     (out_scale_x),
        .out_scale_y     (out_scale_y),
        .key_event       (key_event),
        .event_index     (event_index),
        .is_playing      (is_playing)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after transfer");

    a_zero_without_transform: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !transform_valid |-> (out_pos_x == 0) && (out_pos_y == 0) &&
        (out_rotation == 0) && (out_scale_x == 0) && (out_scale_y == 0))
        else $error("channels nonzero without transform");

    a_index_without_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_event |-> event_index == 0)
        else $error("event index set without event");

    a_event_while_playing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event |-> is_playing)
        else $error("keyframe event while not playing");

endmodule

/* tb/tb_keyframe_transform_interpolator_core.sv */
// Self-checking testbench for the keyframe transform interpolator core.
module tb_keyframe_transform_interpolator_core;
    import kti_pkg::*;

    localparam int N_CLIP     = 8;
    localparam int N_KEY      = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int ITEMS      = 750;

    typedef struct {
        logic [2:0]  opc;
        logic [2:0]  clip_no;
        logic [3:0]  slot_no;
        logic        last;
        logic [31:0] ktime;
        logic [31:0] val[5];
        logic [31:0] tnow;
    } cmd_item_t;

    typedef struct {
        logic        tv;
        logic [31:0] ch[5];
        logic        ev;
        logic [3:0]  ev_idx;
        logic        playing;
    } xform_t;

    typedef struct {
        cmd_item_t it;
        bit        fixed;
        xform_t    res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] op = '0;
    logic [CLIP_IN_W-1:0] clip = '0;
    logic [KEY_W-1:0] slot = '0;
    logic key_last = 1'b0;
    logic [31:0] key_time = '0;
    logic signed [31:0] key_pos_x = '0, key_pos_y = '0, key_rotation = '0;
    logic signed [31:0] key_scale_x = '0, key_scale_y = '0;
    logic [31:0] now = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic transform_valid;
    logic signed [31:0] out_pos_x, out_pos_y, out_rotation, out_scale_x, out_scale_y;
    logic key_event;
    logic [KEY_W-1:0] event_index;
    logic is_playing;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SPEED_W-1:0] speed = SPEED_RESET;

    keyframe_transform_interpolator_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .clip(clip), .slot(slot), .key_last(key_last), .key_time(key_time),
        .key_pos_x(key_pos_x), .key_pos_y(key_pos_y), .key_rotation(key_rotation),
        .key_scale_x(key_scale_x), .key_scale_y(key_scale_y), .now(now),
        .out_valid(out_valid), .out_stall(out_stall),
        .transform_valid(transform_valid),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_rotation(out_rotation),
        .out_scale_x(out_scale_x), .out_scale_y(out_scale_y),
        .key_event(key_event), .event_index(event_index), .is_playing(is_playing),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .speed(speed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow state of the block
    logic [31:0] key_times[N_CLIP][N_KEY];
    logic [31:0] key_vals[N_CLIP][N_KEY][5];
    bit          key_loaded[N_CLIP][N_KEY];
    logic [4:0]  clip_len[N_CLIP];
    bit          playing;
    logic [2:0]  cur_clip;
    logic [3:0]  cur_key;
    logic [31:0] play_start;
    logic [15:0] speed_q;

    xform_t expected_xforms[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_reqs = 0;
    int     hold_done = 0;
    int     hold_cnt = 0;
    int     quiet_cycles = 0;

    function automatic logic [31:0] lerp(logic [31:0] v1, logic [31:0] v2,
                                         logic [63:0] n, logic [63:0] d);
        longint a, diff, r;
        logic [63:0] mag, q;
        a = longint'(signed'(v1));
        diff = longint'(signed'(v2)) - a;
        mag = diff < 0 ? -diff : diff;
        q = mag * n / d;
        r = diff < 0 ? a - longint'(q) : a + longint'(q);
        return r[31:0];
    endfunction

    function automatic xform_t interpolate(cmd_item_t it);
        xform_t r;
        logic [31:0] dt;
        logic [63:0] el, t1, t2, tm;
        r.tv = 1'b0;
        r.ev = 1'b0;
        r.ev_idx = '0;
        for (int c = 0; c < 5; c++) r.ch[c] = '0;
        case (it.opc)
            OP_LOAD:
            begin
                key_times[it.clip_no][it.slot_no] = it.ktime;
                key_vals[it.clip_no][it.slot_no] = it.val;
                key_loaded[it.clip_no][it.slot_no] = 1'b1;
                if (it.last) clip_len[it.clip_no] = it.slot_no + 5'd1;
            end
            OP_CLEAR:
            begin
                if (playing && cur_clip == it.clip_no)
                begin
                    playing = 1'b0;
                    play_start = it.tnow;
                    cur_key = '0;
                end
                clip_len[it.clip_no] = '0;
            end
            OP_PLAY:
            begin
                if (clip_len[it.clip_no] != 0)
                begin
                    playing = 1'b1;
                    cur_clip = it.clip_no;
                    play_start = it.tnow;
                    cur_key = '0;
                    r.ev = 1'b1;
                end
            end
            OP_REPLAY:
            begin
                play_start = it.tnow;
                cur_key = '0;
            end
            OP_STOP:
            begin
                playing = 1'b0;
                play_start = it.tnow;
                cur_key = '0;
            end
            OP_TICK:
            begin
                if (playing && {1'b0, cur_key} + 5'd1 < clip_len[cur_clip])
                begin
                    t1 = key_times[cur_clip][cur_key];
                    t2 = key_times[cur_clip][cur_key + 1];
                    dt = it.tnow - play_start;
                    el = ({32'b0, dt} * {48'b0, speed_q}) >> SPEED_FRAC;
                    for (int c = 0; c < 5; c++)
                    begin
                        if (t2 <= t1)
                            r.ch[c] = key_vals[cur_clip][cur_key + 1][c];
                        else
                        begin
                            tm = el < t2 ? el : t2;
                            if (tm < t1) tm = t1;
                            r.ch[c] = lerp(key_vals[cur_clip][cur_key][c],
                                           key_vals[cur_clip][cur_key + 1][c],
                                           tm - t1, t2 - t1);
                        end
                    end
                    r.tv = 1'b1;
                    if (el >= t2)
                    begin
                        cur_key++;
                        r.ev = 1'b1;
                        r.ev_idx = cur_key;
                    end
                end
            end
            default: ;
        endcase
        r.playing = playing;
        return r;
    endfunction

    task automatic send(cmd_item_t it, bit fixed = 1'b0, xform_t fr = '{default: '0});
        xform_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op <= it.opc;
        clip <= it.clip_no;
        slot <= it.slot_no;
        key_last <= it.last;
        key_time <= it.ktime;
        key_pos_x <= it.val[0];
        key_pos_y <= it.val[1];
        key_rotation <= it.val[2];
        key_scale_x <= it.val[3];
        key_scale_y <= it.val[4];
        now <= it.tnow;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        p = interpolate(it);
        expected_xforms.push_back(fixed ? fr : p);
        items_sent++;
    endtask

    function automatic cmd_item_t mk(logic [2:0] o, logic [2:0] c, logic [3:0] s,
                                     logic l, logic [31:0] t, logic [31:0] base,
                                     logic [31:0] tn);
        cmd_item_t it;
        it.opc = o;
        it.clip_no = c;
        it.slot_no = s;
        it.last = l;
        it.ktime = t;
        for (int k = 0; k < 5; k++) it.val[k] = base ^ (k * 32'h0101_0101);
        it.tnow = tn;
        return it;
    endfunction

    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        it.opc = 3'($urandom_range(7));
        it.clip_no = 3'($urandom_range(7));
        it.slot_no = 4'($urandom_range(15));
        it.last = 1'($urandom_range(1));
        it.ktime = $urandom;
        for (int k = 0; k < 5; k++) it.val[k] = $urandom;
        it.tnow = $urandom;
        // never mark a clip end that would expose unloaded keyframes
        for (int s = 0; s < it.slot_no; s++)
            if (!key_loaded[it.clip_no][s]) it.last = 1'b0;
        return it;
    endfunction

    // well-formed clip: load in order, play, then a run of ticks with the odd replay, stop or clear
    task automatic play_sequence();
        int n, cl;
        logic [31:0] t, t0, off;
        cmd_item_t it;
        cl = $urandom_range(7);
        n = ($urandom_range(9) == 0) ? 16 : $urandom_range(2, 5);
        t = $urandom_range(0, 1 << 16);
        for (int s = 0; s < n; s++)
        begin
            it = rand_item();
            it.opc = OP_LOAD;
            it.clip_no = 3'(cl);
            it.slot_no = 4'(s);
            it.last = (s == n - 1);
            it.ktime = t;
            send(it);
            t += ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 1 << 20);
        end
        t0 = $urandom;
        send(mk(OP_PLAY, 3'(cl), 0, 0, 0, 0, t0));
        off = 0;
        for (int k = 0; k < 2 * n + 2; k++)
        begin
            off += $urandom_range(0, 1 << 19);
            case ($urandom_range(19))
                0: send(mk(OP_REPLAY, 0, 0, 0, 0, 0, t0));
                1: send(mk(OP_STOP, 0, 0, 0, 0, 0, t0 + off));
                2: send(mk(OP_CLEAR, 3'(cl), 0, 0, 0, 0, t0 + off));
                default: send(mk(OP_TICK, 0, 0, 0, 0, 0, t0 + off));
            endcase
        end
    endtask

    task automatic drain();
        while (expected_xforms.size() != 0) @(posedge clk);
    endtask

    task automatic write_speed(logic [15:0] v);
        // drop valid first so the last item is not offered again
        in_valid <= 1'b0;
        drain();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        speed <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        speed_q = v;
    endtask

    function automatic xform_t fx(logic tv, logic ev, logic [3:0] ei, logic pl);
        xform_t r;
        r = '{default: '0};
        r.tv = tv;
        r.ev = ev;
        r.ev_idx = ei;
        r.playing = pl;
        return r;
    endfunction

    // result side: random stall, long hold-off on request, in-order compare
    always @(posedge clk)
    begin
        xform_t e;
        logic [31:0] got[5];
        if (out_valid && !out_stall)
        begin
            got = '{out_pos_x, out_pos_y, out_rotation, out_scale_x, out_scale_y};
            if (expected_xforms.size() == 0)
            begin
                $error("unexpected transfer on the result channel");
                mismatches++;
            end
            else
            begin
                e = expected_xforms.pop_front();
                if (transform_valid !== e.tv)
                begin
                    $error("transform_valid: expected %0d, got %0d", e.tv, transform_valid);
                    mismatches++;
                end
                for (int c = 0; c < 5; c++)
                    if (got[c] !== e.ch[c])
                    begin
                        $error("channel %s: expected %h, got %h",
                               c == 0 ? "out_pos_x" : c == 1 ? "out_pos_y" :
                               c == 2 ? "out_rotation" : c == 3 ? "out_scale_x" :
                               "out_scale_y", e.ch[c], got[c]);
                        mismatches++;
                    end
                if (key_event !== e.ev)
                begin
                    $error("key_event: expected %0d, got %0d", e.ev, key_event);
                    mismatches++;
                end
                if (event_index !== e.ev_idx)
                begin
                    $error("event_index: expected %0d, got %0d", e.ev_idx, event_index);
                    mismatches++;
                end
                if (is_playing !== e.playing)
                begin
                    $error("is_playing: expected %0d, got %0d", e.playing, is_playing);
                    mismatches++;
                end
            end
        end
        if (hold_cnt == 0 && hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_cnt = HOLD_LEN;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("** keyframe_transform_interpolator_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir[$];
        logic [15:0] speeds[6];
        int target;
        for (int c = 0; c < N_CLIP; c++)
        begin
            clip_len[c] = '0;
            for (int s = 0; s < N_KEY; s++) key_loaded[c][s] = 1'b0;
        end
        playing = 1'b0;
        cur_clip = '0;
        cur_key = '0;
        play_start = '0;
        speed_q = SPEED_RESET;

        dir = '{
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, fx(0, 0, 0, 0)},
            '{mk(OP_PLAY, 0, 0, 0, 0, 0, 0), 1, fx(0, 0, 0, 0)},
            '{mk(3'd6, 7, 15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, fx(0, 0, 0, 0)},
            '{mk(3'd7, 0, 0, 0, 0, 0, 0), 1, fx(0, 0, 0, 0)},
            '{mk(OP_LOAD, 0, 0, 0, 0, 32'h8000_0000, 0), 1, fx(0, 0, 0, 0)},
            '{mk(OP_LOAD, 0, 1, 1, 32'h0001_0000, 32'h7FFF_FFFF, 0), 1, fx(0, 0, 0, 0)},
            '{mk(OP_PLAY, 0, 0, 0, 0, 0, 0), 1, fx(0, 1, 0, 1)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_8000), 0, fx(0, 0, 0, 0)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0001_0000), 0, fx(0, 0, 0, 0)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0002_0000), 1, fx(0, 0, 0, 1)},
            '{mk(OP_REPLAY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, fx(0, 0, 0, 1)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_7FFF), 0, fx(0, 0, 0, 0)},
            '{mk(OP_LOAD, 1, 0, 0, 32'hFFFF_FFFF, 32'h1234_5678, 0), 1, fx(0, 0, 0, 1)},
            '{mk(OP_LOAD, 1, 1, 1, 32'h0000_0005, 32'hEDCB_A987, 0), 1, fx(0, 0, 0, 1)},
            '{mk(OP_PLAY, 1, 0, 0, 0, 0, 0), 1, fx(0, 1, 0, 1)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, fx(0, 0, 0, 0)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_0010), 0, fx(0, 0, 0, 0)},
            '{mk(OP_CLEAR, 1, 0, 0, 0, 0, 7), 1, fx(0, 0, 0, 0)},
            '{mk(OP_LOAD, 2, 0, 0, 32'h0000_0100, 32'h0000_0000, 0), 1, fx(0, 0, 0, 0)},
            '{mk(OP_LOAD, 2, 1, 1, 32'h0000_0200, 32'hFFFF_FFFF, 0), 1, fx(0, 0, 0, 0)},
            '{mk(OP_PLAY, 2, 0, 0, 0, 0, 0), 1, fx(0, 1, 0, 1)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_0010), 0, fx(0, 0, 0, 0)},
            '{mk(OP_CLEAR, 3, 0, 0, 0, 0, 0), 1, fx(0, 0, 0, 1)},
            '{mk(OP_STOP, 0, 0, 0, 0, 0, 32'h0000_0042), 1, fx(0, 0, 0, 0)},
            '{mk(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_0180), 1, fx(0, 0, 0, 0)}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i]) send(dir[i].it, dir[i].fixed, dir[i].res);

        speeds = '{16'd0, 16'd65535, 16'd1, 16'd256, 16'($urandom_range(128, 512)), 16'd384};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_speed(speeds[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 3) hold_reqs++;
            target = items_sent + ITEMS / 6;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 65)
                    play_sequence();
                else
                    send(rand_item());
                if (ph == 4 && items_sent > target - ITEMS / 12)
                begin
                    // pause the input until the output side has caught up
                    in_valid <= 1'b0;
                    @(posedge clk);
                    drain();
                    ph = 5;
                    ph = 4;
                end
            end
        end
        in_valid <= 1'b0;
        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("** keyframe_transform_interpolator_core: PASSED **");
        else
            $display("** keyframe_transform_interpolator_core: FAILED **");
        $finish;
    end

endmodule
